// ----- rtl/sxd_pkg.sv -----
// Shared types, constants and helper functions for the salted XOR packet deframer.
`timescale 1ns / 1ps
package sxd_pkg;

  localparam logic [7:0]  HEADER_BYTES  = 8'd32;
  localparam logic [15:0] MIN_LENGTH    = 16'(HEADER_BYTES) + 16'd1;
  localparam logic [7:0]  HEAD_MAGIC    = 8'h81;
  localparam logic [7:0]  TAIL_MAGIC    = 8'h7e;
  localparam logic [16:0] BODY_SUM_FROM = 17'd28;

  localparam logic OUT_BODY   = 1'b0;
  localparam logic OUT_STATUS = 1'b1;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_HEAD    = 4'd2;
  localparam logic [3:0] ST_TAIL    = 4'd3;
  localparam logic [3:0] ST_HDR_SUM = 4'd4;
  localparam logic [3:0] ST_OFFSET  = 4'd5;
  localparam logic [3:0] ST_OVERRUN = 4'd6;
  localparam logic [3:0] ST_BODY_SUM = 4'd7;
  localparam logic [3:0] ST_TRUNC   = 4'd8;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  body_byte;
    logic [3:0]  status;
    logic [7:0]  packet_type;
    logic [7:0]  packet_flag;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [31:0] sequence_no;
    logic [7:0]  retry_count;
    logic [31:0] user_ident;
    logic [31:0] session_key;
    logic [31:0] protocol_word;
  } out_t;

  function automatic logic [7:0] salt(input logic [2:0] idx);
    logic [7:0] s;
    case (idx)
      3'd0: s = 8'h74;
      3'd1: s = 8'he8;
      3'd2: s = 8'ha6;
      3'd3: s = 8'h97;
      3'd4: s = 8'h2e;
      3'd5: s = 8'h3c;
      3'd6: s = 8'h59;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // 8 = 1 mod 7, so octal digit sums keep the residue
  function automatic logic [2:0] mod7(input logic [16:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
       + 6'(x[16:15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    return (s3 == 4'd7) ? 3'd0 : s3[2:0];
  endfunction

  function automatic logic [2:0] add3mod7(input logic [2:0] x);
    return (x >= 3'd4) ? (x - 3'd4) : (x + 3'd3);
  endfunction

endpackage

// ----- rtl/sxd_core.sv -----
// Parser state and per-byte decode for the deframer.
`timescale 1ns / 1ps
module sxd_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  sxd_pkg::in_t item,
  output logic         res_valid,
  output sxd_pkg::out_t res
);
  import sxd_pkg::*;

  logic        active, active_next;
  logic [15:0] pos, pos_next;
  logic [2:0]  pm7, pm7_next;
  logic [15:0] plen, plen_next;
  logic [7:0]  hxor, hxor_next;
  logic [7:0]  bxor, bxor_next;
  logic [7:0]  exp_hsum, exp_hsum_next;
  logic [7:0]  exp_bsum, exp_bsum_next;
  logic [15:0] blen, blen_next;
  logic [7:0]  bstart, bstart_next;
  logic [16:0] bend, bend_next;
  logic [2:0]  bsalt, bsalt_next;
  logic [3:0]  perr, perr_next;
  out_t        hdr, hdr_next;

  logic [7:0]  b;
  logic        last;
  logic        in_body;
  logic [7:0]  eff_start;
  logic [16:0] eff_end;
  logic [3:0]  code;

  assign b         = item.byte_value;
  assign last      = ({1'b0, pos} + 17'd1) == {1'b0, plen};
  assign in_body   = (17'(pos) >= BODY_SUM_FROM) && (perr == ST_OK)
                     && ({1'b0, pos} < bend);
  assign eff_start = (b == 8'd0) ? HEADER_BYTES : b;
  assign eff_end   = 17'(eff_start) + 17'(blen);

  always_comb begin
    if (b != TAIL_MAGIC) begin
      code = ST_TAIL;
    end else if ((hxor ^ salt(add3mod7(pm7))) != exp_hsum) begin
      code = ST_HDR_SUM;
    end else if (perr != ST_OK) begin
      code = perr;
    end else if ((bxor ^ salt(bsalt)) != exp_bsum) begin
      code = ST_BODY_SUM;
    end else begin
      code = ST_OK;
    end
  end

  always_comb begin
    active_next   = active;
    pos_next      = pos;
    pm7_next      = pm7;
    plen_next     = plen;
    hxor_next     = hxor;
    bxor_next     = bxor;
    exp_hsum_next = exp_hsum;
    exp_bsum_next = exp_bsum;
    blen_next     = blen;
    bstart_next   = bstart;
    bend_next     = bend;
    bsalt_next    = bsalt;
    perr_next     = perr;
    hdr_next      = hdr;
    res_valid     = 1'b0;
    res           = '0;

    if (fire) begin
      if (item.frame_start) begin
        if (active) begin
          res_valid       = 1'b1;
          res             = hdr;
          res.out_kind    = OUT_STATUS;
          res.status      = ST_TRUNC;
        end
        active_next   = 1'b1;
        pos_next      = 16'd1;
        pm7_next      = 3'd1;
        plen_next     = {b, 8'h00};
        hxor_next     = '0;
        bxor_next     = '0;
        exp_hsum_next = '0;
        exp_bsum_next = '0;
        blen_next     = '0;
        bstart_next   = '0;
        bend_next     = '0;
        bsalt_next    = '0;
        perr_next     = ST_OK;
        hdr_next      = '0;
      end else if (active) begin
        pos_next = pos + 16'd1;
        pm7_next = (pm7 == 3'd6) ? 3'd0 : pm7 + 3'd1;
        if (pos == 16'd0) begin
          plen_next = {b, 8'h00};
        end else if (pos == 16'd1) begin
          plen_next = {plen[15:8], b};
          if ({plen[15:8], b} < MIN_LENGTH) begin
            res_valid   = 1'b1;
            res         = hdr;
            res.out_kind = OUT_STATUS;
            res.status  = ST_SHORT;
            active_next = 1'b0;
          end
        end else if (pos == 16'd2) begin
          if (b != HEAD_MAGIC) begin
            res_valid   = 1'b1;
            res         = hdr;
            res.out_kind = OUT_STATUS;
            res.status  = ST_HEAD;
            active_next = 1'b0;
          end
        end else if (pos == 16'd3) begin
          exp_hsum_next = b;
        end else if (last) begin
          res_valid    = 1'b1;
          res          = hdr;
          res.out_kind = OUT_STATUS;
          res.status   = code;
          active_next  = 1'b0;
        end else begin
          hxor_next = hxor ^ b;
          if (pos[15:5] == 11'd0) begin
            case (pos[4:0])
              5'd4:  hdr_next.packet_type          = b;
              5'd5:  hdr_next.packet_flag          = b;
              5'd6:  hdr_next.source_id            = b;
              5'd7:  hdr_next.dest_id              = b;
              5'd8:  hdr_next.sequence_no[31:24]   = b;
              5'd9:  hdr_next.sequence_no[23:16]   = b;
              5'd10: hdr_next.sequence_no[15:8]    = b;
              5'd11: hdr_next.sequence_no[7:0]     = b;
              5'd12: hdr_next.retry_count          = b;
              5'd16: hdr_next.user_ident[31:24]    = b;
              5'd17: hdr_next.user_ident[23:16]    = b;
              5'd18: hdr_next.user_ident[15:8]     = b;
              5'd19: hdr_next.user_ident[7:0]      = b;
              5'd20: hdr_next.session_key[31:24]   = b;
              5'd21: hdr_next.session_key[23:16]   = b;
              5'd22: hdr_next.session_key[15:8]    = b;
              5'd23: hdr_next.session_key[7:0]     = b;
              5'd24: blen_next                     = {b, 8'h00};
              5'd25: blen_next                     = {blen[15:8], b};
              5'd26: begin
                if (b != 8'd0 && b < HEADER_BYTES) begin
                  bstart_next = b;
                  bend_next   = 17'(b) + 17'(blen);
                  perr_next   = ST_OFFSET;
                end else begin
                  bstart_next = eff_start;
                  bend_next   = eff_end;
                  if (eff_end >= {1'b0, plen}) begin
                    perr_next = ST_OVERRUN;
                  end
                end
              end
              5'd27: begin
                exp_bsum_next = b;
                bsalt_next    = mod7(bend - BODY_SUM_FROM);
              end
              5'd28: hdr_next.protocol_word[31:24] = b;
              5'd29: hdr_next.protocol_word[23:16] = b;
              5'd30: hdr_next.protocol_word[15:8]  = b;
              5'd31: hdr_next.protocol_word[7:0]   = b;
              default: ;
            endcase
          end
          if (in_body) begin
            bxor_next = bxor ^ b;
            if (pos >= 16'(bstart)) begin
              res_valid     = 1'b1;
              res.out_kind  = OUT_BODY;
              res.body_byte = b;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pos      <= '0;
      pm7      <= '0;
      plen     <= '0;
      hxor     <= '0;
      bxor     <= '0;
      exp_hsum <= '0;
      exp_bsum <= '0;
      blen     <= '0;
      bstart   <= '0;
      bend     <= '0;
      bsalt    <= '0;
      perr     <= ST_OK;
      hdr      <= '0;
    end else begin
      active   <= active_next;
      pos      <= pos_next;
      pm7      <= pm7_next;
      plen     <= plen_next;
      hxor     <= hxor_next;
      bxor     <= bxor_next;
      exp_hsum <= exp_hsum_next;
      exp_bsum <= exp_bsum_next;
      blen     <= blen_next;
      bstart   <= bstart_next;
      bend     <= bend_next;
      bsalt    <= bsalt_next;
      perr     <= perr_next;
      hdr      <= hdr_next;
    end
  end

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    fire && item.frame_start |=> active && pos == 16'd1)
    else $error("start byte did not open a packet");

  a_body_keeps_open: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_kind == OUT_BODY |=> active)
    else $error("packet closed after a body byte");

  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_kind == OUT_STATUS && !item.frame_start |=> !active)
    else $error("packet still open after final status");

endmodule

// ----- rtl/salted_xor_packet_deframer_top.sv -----
// Top level of the salted XOR packet deframer: handshakes and result register.
//
// Input channel stream/stream_valid/stream_stall carries one packet byte per
// transfer; frame_start marks the first byte of a packet. Output channel
// result/result_valid/result_stall carries body bytes (out_kind 0) and one
// final status per packet (out_kind 1) with the decoded header fields.
// A result appears in the result register in the cycle after the input
// transfer that causes it.
// Throughput: one byte per cycle while stream_stall is low; the parser
// decodes each byte combinationally; the result register frees when drained.
// Bytes that cause no result still advance the parser.
// While result_valid is high and result_stall is high, stream_stall is
// raised and the held result stays unchanged.
// Reset (rst, synchronous) closes any open packet and empties the result
// register; bytes before the next frame_start are dropped.
`timescale 1ns / 1ps
module salted_xor_packet_deframer_top (
  input  logic          clk,
  input  logic          rst,
  input  sxd_pkg::in_t  stream,
  input  logic          stream_valid,
  output logic          stream_stall,
  output sxd_pkg::out_t result,
  output logic          result_valid,
  input  logic          result_stall
);
  import sxd_pkg::*;

  logic fire;
  logic res_valid;
  out_t res;

  assign stream_stall = result_valid && result_stall;
  assign fire         = stream_valid && !stream_stall;

  sxd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (stream),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= res_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      result <= res;
    end
  end

  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_kind == OUT_BODY |->
      result.status == ST_OK && result.sequence_no == 32'd0
      && result.protocol_word == 32'd0)
    else $error("body transfer carries header fields");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_kind == OUT_STATUS |-> result.body_byte == 8'd0)
    else $error("status transfer carries a body byte");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= ST_TRUNC)
    else $error("status code out of range");

endmodule
